>>> src/bpq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpq_pkg
// Shared types and constants of the beep pattern queue player: field widths,
// request codes, register indexes and the queue command and status words.
// ----------------------------------------------------------------------------
package bpq_pkg;

  // Field widths of one input word and one result word.
  localparam int FUNC_W     = 2;
  localparam int SEQ_W      = 4;
  localparam int STEP_W     = 4;
  localparam int DUR_W      = 8;
  localparam int LEN_W      = 5;
  localparam int COUNT_W    = 4;

  // Stream and configuration port widths.
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Request kinds carried in tuser.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK = 2'd0,
    FUNC_PLAY = 2'd1,
    FUNC_STOP = 2'd2,
    FUNC_LOAD = 2'd3
  } func_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAUSE_TICKS   = 1'd0,
    CFG_INVERT_OUTPUT = 1'd1
  } cfg_idx_t;

  // Operations of the queue sequencer.
  typedef enum logic [1:0] {
    QOP_PLAY      = 2'd0,
    QOP_STOP      = 2'd1,
    QOP_DROP_HEAD = 2'd2
  } qop_t;

  typedef struct packed {
    logic             start;
    qop_t             op;
    logic             keep_head;
    logic [SEQ_W-1:0] pat;
  } q_cmd_t;

  typedef struct packed {
    logic             done;
    logic             dropped;
    logic [SEQ_W-1:0] head;
  } q_stat_t;

endpackage
`default_nettype wire

>>> src/bpq_store_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpq_store_ram
// Pattern duration store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bpq_store_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 8
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  // Read data is registered; a same-address read sees the old word.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> src/bpq_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpq_queue
// Request queue held in a small synchronous memory. A sequencer compacts the
// queue in place (purge of one pattern or removal of the head), then appends
// a pattern for a play request. A copy of entry zero is kept as the head.
// ----------------------------------------------------------------------------
module bpq_queue #(
  parameter  int QUEUE_DEPTH = 8,
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire bpq_pkg::q_cmd_t  cmd,
  output bpq_pkg::q_stat_t      stat,
  output logic      [CNT_W-1:0] count
);
  import bpq_pkg::*;

  localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  typedef enum logic [1:0] {Q_IDLE, Q_SCAN, Q_FINISH} qstate_t;

  qstate_t          state_r, state_nxt;
  qop_t             op_r, op_nxt;
  logic [SEQ_W-1:0] pat_r, pat_nxt;
  logic [SEQ_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rd_k_r, rd_k_nxt;
  logic [CNT_W-1:0] wr_w_r, wr_w_nxt;
  logic             pend_r, pend_nxt;
  logic             done_r, done_nxt;
  logic             dropped_r, dropped_nxt;
  logic [CNT_W-1:0] start_k;

  logic [SEQ_W-1:0] mem [QUEUE_DEPTH];
  logic [SEQ_W-1:0] rd_data_r;
  logic             rd_en, wr_en;
  logic [SEQ_W-1:0] wr_data;

  // Sequencer: reads run ahead of the compacting writes.
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    pat_nxt     = pat_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    rd_k_nxt    = rd_k_r;
    wr_w_nxt    = wr_w_r;
    pend_nxt    = pend_r;
    done_nxt    = 1'b0;
    dropped_nxt = dropped_r;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_data     = rd_data_r;
    start_k     = CNT_W'(cmd.keep_head);
    unique case (state_r)
      Q_IDLE: begin
        if (cmd.start) begin
          op_nxt      = cmd.op;
          pat_nxt     = cmd.pat;
          dropped_nxt = 1'b0;
          pend_nxt    = 1'b0;
          state_nxt   = Q_SCAN;
          if (cmd.op == QOP_DROP_HEAD) begin
            rd_k_nxt = ONE_C;
            wr_w_nxt = '0;
          end else begin
            rd_k_nxt = start_k;
            wr_w_nxt = (start_k < count_r) ? start_k : count_r;
          end
        end
      end
      Q_SCAN: begin
        pend_nxt = (rd_k_r < count_r);
        if (rd_k_r < count_r) begin
          rd_en    = 1'b1;
          rd_k_nxt = rd_k_r + ONE_C;
        end
        // Keep the entry read last cycle unless it is a copy being purged.
        if (pend_r && (op_r == QOP_DROP_HEAD || rd_data_r != pat_r)) begin
          wr_en    = 1'b1;
          wr_w_nxt = wr_w_r + ONE_C;
          if (wr_w_r == '0) begin
            head_nxt = rd_data_r;
          end
        end
        if (rd_k_r >= count_r && !pend_r) begin
          state_nxt = Q_FINISH;
        end
      end
      Q_FINISH: begin
        count_nxt = wr_w_r;
        if (op_r == QOP_PLAY) begin
          if (wr_w_r < DEPTH_C) begin
            wr_en     = 1'b1;
            wr_data   = pat_r;
            count_nxt = wr_w_r + ONE_C;
            if (wr_w_r == '0) begin
              head_nxt = pat_r;
            end
          end else begin
            dropped_nxt = 1'b1;
          end
        end
        done_nxt  = 1'b1;
        state_nxt = Q_IDLE;
      end
      default: begin
        state_nxt = Q_IDLE;
      end
    endcase
  end

  // State and status registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= Q_IDLE;
      count_r   <= '0;
      pend_r    <= 1'b0;
      done_r    <= 1'b0;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      pend_r    <= pend_nxt;
      done_r    <= done_nxt;
      dropped_r <= dropped_nxt;
    end
    op_r   <= op_nxt;
    pat_r  <= pat_nxt;
    head_r <= head_nxt;
    rd_k_r <= rd_k_nxt;
    wr_w_r <= wr_w_nxt;
  end

  // Queue memory: write at the compaction pointer, read at the scan pointer.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_w_r[QA_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_k_r[QA_W-1:0]];
    end
  end

  assign stat.done    = done_r;
  assign stat.dropped = dropped_r;
  assign stat.head    = head_r;
  assign count        = count_r;

endmodule
`default_nettype wire

>>> src/beep_pattern_queue_player_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// beep_pattern_queue_player_top
// Buzzer pattern player: loads patterns into a store, queues play requests,
// and steps the pin level through the head pattern on each 10 ms tick.
//
//   Channel  Direction  Handshake             Payload
//   in_      slave      in_tvalid/in_tready   tuser: func; tdata: pattern fields
//   out_     master     out_tvalid/out_tready tdata: pin, count, pause, dropped
//   cfg_     slave      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// Load and plain tick words pass the execute and result states; a tick that
// fetches a duration also passes the store-read state. Play, stop and a
// tick that retires the head wait in the queue-wait state for the compaction
// pass over the queue memory port. One word is in work at a time; the next
// is taken in the cycle in which a result appears, even while it waits,
// and a held result stalls only the final step of the following word.
// Reset is synchronous and clears control state and pattern lengths.
// ----------------------------------------------------------------------------
module beep_pattern_queue_player_top #(
  parameter int QUEUE_DEPTH  = 8,
  parameter int NUM_PATTERNS = 16,
  parameter int MAX_STEPS    = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Configuration write channel.
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [bpq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bpq_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Request words.
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [3:0] seq_index, [7:4] step_index, [15:8] duration, [20:16] seq_length
  input  wire logic [bpq_pkg::IN_DATA_W-1:0]    in_tdata,
  // [1:0] func
  input  wire logic [bpq_pkg::IN_USER_W-1:0]    in_tuser,
  // Result words.
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [0] pin_level, [4:1] queue_count, [5] in_pause, [6] dropped
  output logic [bpq_pkg::OUT_DATA_W-1:0]        out_tdata
);
  import bpq_pkg::*;

  localparam int ST_DEPTH = NUM_PATTERNS * MAX_STEPS;
  localparam int ST_AW    = (ST_DEPTH > 1) ? $clog2(ST_DEPTH) : 1;
  localparam int PAT_W    = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_LOAD, S_QWAIT, S_RESULT} state_t;

  state_t              state_r, state_nxt;
  func_t               func_r, func_nxt;
  logic [SEQ_W-1:0]    pat_r, pat_nxt;
  logic [STEP_W-1:0]   pos_r, pos_nxt;
  logic [DUR_W-1:0]    dur_r, dur_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [DUR_W-1:0]    pause_ticks_r, pause_ticks_nxt;
  logic                invert_r, invert_nxt;
  logic [DUR_W-1:0]    wait_r, wait_nxt;
  logic [LEN_W-1:0]    step_r, step_nxt;
  logic                pausing_r, pausing_nxt;
  logic                beep_r, beep_nxt;
  logic                start_r, start_nxt;
  logic                dropped_r, dropped_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [LEN_W-1:0]    len_mem_r [NUM_PATTERNS];

  logic                len_we;
  logic [PAT_W-1:0]    len_wa;
  logic [LEN_W-1:0]    len_wd;
  logic [DUR_W-1:0]    wait_dec;
  logic [PAT_W-1:0]    head_idx;
  logic [COUNT_W-1:0]  count_sat;

  logic                st_wr_en, st_rd_en;
  logic [ST_AW-1:0]    st_wr_addr, st_rd_addr;
  logic [DUR_W-1:0]    st_rd_data;

  q_cmd_t              q_cmd;
  q_stat_t             q_stat;
  logic [CNT_W-1:0]    q_count;

  bpq_store_ram #(
    .DEPTH (ST_DEPTH),
    .AW    (ST_AW),
    .DW    (DUR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (dur_r),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  bpq_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (q_cmd),
    .stat  (q_stat),
    .count (q_count)
  );

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign wait_dec  = (wait_r != '0) ? wait_r - DUR_W'(1) : wait_r;
  assign head_idx  = PAT_W'(q_stat.head);
  assign count_sat = (int'(q_count) > 15) ? COUNT_W'(15) : COUNT_W'(q_count);
  assign st_wr_addr = ST_AW'(ST_AW'(pat_r) * ST_AW'(MAX_STEPS) + ST_AW'(pos_r));
  assign st_rd_addr = ST_AW'(ST_AW'(q_stat.head) * ST_AW'(MAX_STEPS) + ST_AW'(step_r));

  // Controller: decode the word, drive the store and queue, build the result.
  always_comb begin
    state_nxt       = state_r;
    func_nxt        = func_r;
    pat_nxt         = pat_r;
    pos_nxt         = pos_r;
    dur_nxt         = dur_r;
    len_nxt         = len_r;
    pause_ticks_nxt = pause_ticks_r;
    invert_nxt      = invert_r;
    wait_nxt        = wait_r;
    step_nxt        = step_r;
    pausing_nxt     = pausing_r;
    beep_nxt        = beep_r;
    start_nxt       = start_r;
    dropped_nxt     = dropped_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_data_nxt    = out_data_r;
    len_we          = 1'b0;
    len_wa          = PAT_W'(pat_r);
    len_wd          = (int'(len_r) > MAX_STEPS) ? LEN_W'(MAX_STEPS) : len_r;
    st_wr_en        = 1'b0;
    st_rd_en        = 1'b0;
    q_cmd.start     = 1'b0;
    q_cmd.op        = QOP_STOP;
    q_cmd.keep_head = !pausing_r;
    q_cmd.pat       = pat_r;

    // Configuration writes land at once.
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PAUSE_TICKS:   pause_ticks_nxt = cfg_data;
        CFG_INVERT_OUTPUT: invert_nxt      = cfg_data[0];
        default:           pause_ticks_nxt = pause_ticks_r;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          func_nxt    = func_t'(in_tuser[FUNC_W-1:0]);
          pat_nxt     = in_tdata[3:0];
          pos_nxt     = in_tdata[7:4];
          dur_nxt     = in_tdata[15:8];
          len_nxt     = in_tdata[20:16];
          dropped_nxt = 1'b0;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_RESULT;
        unique case (func_r)
          FUNC_TICK: begin
            wait_nxt = wait_dec;
            if (wait_dec == '0) begin
              if (pausing_r) begin
                // Pause over: start the head pattern from its first entry.
                pausing_nxt = 1'b0;
                if (q_count != '0) begin
                  step_nxt  = '0;
                  start_nxt = 1'b1;
                  st_rd_en  = 1'b1;
                  state_nxt = S_LOAD;
                end
              end else if (q_count != '0) begin
                if (step_r < len_mem_r[head_idx]) begin
                  start_nxt = 1'b0;
                  st_rd_en  = 1'b1;
                  state_nxt = S_LOAD;
                end else begin
                  // Pattern done: retire it and enter the pause.
                  q_cmd.start = 1'b1;
                  q_cmd.op    = QOP_DROP_HEAD;
                  pausing_nxt = 1'b1;
                  wait_nxt    = pause_ticks_r;
                  step_nxt    = '0;
                  beep_nxt    = 1'b0;
                  state_nxt   = S_QWAIT;
                end
              end
            end
          end
          FUNC_PLAY: begin
            if (int'(pat_r) < NUM_PATTERNS) begin
              q_cmd.start = 1'b1;
              q_cmd.op    = QOP_PLAY;
              state_nxt   = S_QWAIT;
            end
          end
          FUNC_STOP: begin
            q_cmd.start = 1'b1;
            q_cmd.op    = QOP_STOP;
            state_nxt   = S_QWAIT;
          end
          FUNC_LOAD: begin
            if (int'(pat_r) < NUM_PATTERNS) begin
              st_wr_en = (int'(pos_r) < MAX_STEPS);
              len_we   = 1'b1;
            end
          end
          default: begin
            state_nxt = S_RESULT;
          end
        endcase
      end
      S_LOAD: begin
        // Duration from the store arrives this cycle.
        wait_nxt = st_rd_data;
        if (start_r) begin
          beep_nxt = 1'b1;
          step_nxt = LEN_W'(1);
        end else begin
          beep_nxt = !beep_r;
          step_nxt = step_r + LEN_W'(1);
        end
        state_nxt = S_RESULT;
      end
      S_QWAIT: begin
        if (q_stat.done) begin
          dropped_nxt = q_stat.dropped;
          state_nxt   = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, dropped_r, pausing_r, count_sat, beep_r ^ invert_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, player registers and the pattern length table.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      pause_ticks_r <= '0;
      invert_r      <= 1'b0;
      wait_r        <= '0;
      step_r        <= '0;
      pausing_r     <= 1'b0;
      beep_r        <= 1'b0;
      dropped_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < NUM_PATTERNS; i++) begin
        len_mem_r[i] <= '0;
      end
    end else begin
      state_r       <= state_nxt;
      pause_ticks_r <= pause_ticks_nxt;
      invert_r      <= invert_nxt;
      wait_r        <= wait_nxt;
      step_r        <= step_nxt;
      pausing_r     <= pausing_nxt;
      beep_r        <= beep_nxt;
      dropped_r     <= dropped_nxt;
      out_valid_r   <= out_valid_nxt;
      if (len_we) begin
        len_mem_r[len_wa] <= len_wd;
      end
    end
    func_r     <= func_nxt;
    pat_r      <= pat_nxt;
    pos_r      <= pos_nxt;
    dur_r      <= dur_nxt;
    len_r      <= len_nxt;
    start_r    <= start_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

>>> src/bpq_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpq_checker
// Port-level checks of the beep pattern queue player, bound to the top level.
// ----------------------------------------------------------------------------
module bpq_checker #(
  parameter int QUEUE_DEPTH = 8
) (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [bpq_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam logic [3:0] FULL_C = (QUEUE_DEPTH > 15) ? 4'd15 : 4'(QUEUE_DEPTH);

  // A result word held back by the sink stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // The reported queue never exceeds its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[4:1] <= FULL_C)
    else $error("queue count above capacity");

  // A dropped play only happens with the queue full.
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[6] |-> out_tdata[4:1] == FULL_C)
    else $error("play dropped with room in the queue");

  // An accepted word keeps the block busy, so in_tready is low in the cycle after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("word accepted on back-to-back cycles");

endmodule

bind beep_pattern_queue_player_top bpq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_bpq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

>>> dv/beep_player_checker.sv
// ----------------------------------------------------------------------------
// beep_player_checker
// Watches the register, request and result channels of the beep pattern
// queue player. It keeps its own copy of the queue, the pattern store and the
// playback timer, predicts the status word of every accepted request word and
// compares it with the result words in order.
// ----------------------------------------------------------------------------
module beep_player_checker #(
  parameter int QUEUE_DEPTH  = 8,
  parameter int NUM_PATTERNS = 16,
  parameter int MAX_STEPS    = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [bpq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bpq_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  // [3:0] seq_index, [7:4] step_index, [15:8] duration, [20:16] seq_length
  input  logic [bpq_pkg::IN_DATA_W-1:0]    in_tdata,
  // [1:0] func
  input  logic [bpq_pkg::IN_USER_W-1:0]    in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] pin_level, [4:1] queue_count, [5] in_pause, [6] dropped
  input  logic [bpq_pkg::OUT_DATA_W-1:0]   out_tdata,
  output int                               pending_results,
  output int                               fail_count,
  output int                               results_checked,
  output int                               drops_seen
);
  import bpq_pkg::*;

  typedef struct packed {
    logic       dropped;
    logic       in_pause;
    logic [3:0] queue_count;
    logic       pin_level;
  } status_word_t;

  // Register copies.
  logic [7:0] gap_ticks;
  logic       invert_pin;

  // Player state.
  logic [SEQ_W-1:0] play_queue [QUEUE_DEPTH];
  int               queued_n;
  int               step_pos;
  logic             pause_flag;
  logic [7:0]       wait_ticks;
  logic             buzzer_on;
  logic [7:0]       durations [NUM_PATTERNS][MAX_STEPS];
  int               lengths [NUM_PATTERNS];

  status_word_t status_q [$];
  int           pending_r  = 0;
  int           mismatches = 0;
  int           checked_n  = 0;
  int           drops_n    = 0;

  assign pending_results = pending_r;
  assign fail_count      = mismatches;
  assign results_checked = checked_n;
  assign drops_seen      = drops_n;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic clear_player();
    gap_ticks  = '0;
    invert_pin = 1'b0;
    queued_n   = 0;
    step_pos   = 0;
    pause_flag = 1'b0;
    wait_ticks = '0;
    buzzer_on  = 1'b0;
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      lengths[p] = 0;
      for (int s = 0; s < MAX_STEPS; s++) durations[p][s] = '0;
    end
    for (int k = 0; k < QUEUE_DEPTH; k++) play_queue[k] = '0;
  endtask

  // Close the gap left by one queue entry.
  task automatic remove_entry(input int pos);
    if (pos < queued_n) begin
      for (int k = pos; k + 1 < queued_n; k++) play_queue[k] = play_queue[k + 1];
      queued_n--;
    end
  endtask

  // Remove every queued copy of a pattern; the head survives unless in the pause.
  task automatic purge_pattern(input logic [SEQ_W-1:0] pat);
    int k;
    k = pause_flag ? 0 : 1;
    while (k < queued_n) begin
      if (play_queue[k] == pat) remove_entry(k);
      else k++;
    end
  endtask

  function automatic logic [7:0] stored_duration(input int pat, input int pos);
    if (pat >= NUM_PATTERNS || pos >= MAX_STEPS) return '0;
    return durations[pat][pos];
  endfunction

  // One 10 ms tick of the playback timer.
  task automatic advance_tick();
    int head;
    if (wait_ticks != 0) wait_ticks--;
    if (wait_ticks != 0) return;
    if (pause_flag) begin
      // Leaving the gap starts the head pattern with the buzzer on.
      pause_flag = 1'b0;
      if (queued_n == 0) return;
      wait_ticks = stored_duration(int'(play_queue[0]), 0);
      buzzer_on  = 1'b1;
      step_pos   = 1;
      return;
    end
    if (queued_n == 0) return;
    head = int'(play_queue[0]);
    if (head < NUM_PATTERNS && step_pos < lengths[head]) begin
      wait_ticks = stored_duration(head, step_pos);
      step_pos++;
      buzzer_on = ~buzzer_on;
    end else begin
      // Pattern finished: retire it and hold the pin silent for the gap.
      remove_entry(0);
      pause_flag = 1'b1;
      wait_ticks = gap_ticks;
      step_pos   = 0;
      buzzer_on  = 1'b0;
    end
  endtask

  // Apply one request word and queue the status word it should produce.
  task automatic apply_request(input func_t func, input logic [IN_DATA_W-1:0] data);
    logic [SEQ_W-1:0]  pat;
    logic [STEP_W-1:0] pos;
    logic [DUR_W-1:0]  dur;
    logic [LEN_W-1:0]  len;
    status_word_t      want;
    pat = data[3:0];
    pos = data[7:4];
    dur = data[15:8];
    len = data[20:16];
    want = '0;
    case (func)
      FUNC_TICK: advance_tick();
      FUNC_PLAY: begin
        if (pat < NUM_PATTERNS) begin
          purge_pattern(pat);
          if (queued_n < QUEUE_DEPTH) begin
            play_queue[queued_n] = pat;
            queued_n++;
          end else begin
            want.dropped = 1'b1;
          end
        end
      end
      FUNC_STOP: purge_pattern(pat);
      FUNC_LOAD: begin
        if (pat < NUM_PATTERNS) begin
          if (pos < MAX_STEPS) durations[pat][pos] = dur;
          lengths[pat] = (len > MAX_STEPS) ? MAX_STEPS : int'(len);
        end
      end
      default: ;
    endcase
    want.pin_level   = buzzer_on ^ invert_pin;
    want.queue_count = (queued_n > 15) ? 4'd15 : queued_n[3:0];
    want.in_pause    = pause_flag;
    status_q.push_back(want);
  endtask

  always @(posedge clk) begin : watch
    status_word_t want;
    if (!rst_n) begin
      clear_player();
      status_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_PAUSE_TICKS:   gap_ticks  = cfg_data;
          CFG_INVERT_OUTPUT: invert_pin = cfg_data[0];
          default: ;
        endcase
      end
      // Results are matched before new requests so a stray word is never masked.
      if (out_tvalid && out_tready) begin
        if (status_q.size() == 0) begin
          report_mismatch($sformatf("result word %h with no request waiting", out_tdata));
        end else begin
          want = status_q.pop_front();
          checked_n++;
          if (want.dropped) drops_n++;
          if (out_tdata[0] !== want.pin_level)
            report_mismatch($sformatf("pin_level got %b want %b", out_tdata[0],
                                      want.pin_level));
          if (out_tdata[4:1] !== want.queue_count)
            report_mismatch($sformatf("queue_count got %0d want %0d", out_tdata[4:1],
                                      want.queue_count));
          if (out_tdata[5] !== want.in_pause)
            report_mismatch($sformatf("in_pause got %b want %b", out_tdata[5],
                                      want.in_pause));
          if (out_tdata[6] !== want.dropped)
            report_mismatch($sformatf("dropped got %b want %b", out_tdata[6],
                                      want.dropped));
        end
      end
      if (in_tvalid && in_tready) apply_request(func_t'(in_tuser), in_tdata);
    end
    pending_r <= status_q.size();
  end

endmodule

>>> dv/beep_pattern_queue_player_top_tb.sv
// ----------------------------------------------------------------------------
// beep_pattern_queue_player_top_tb
// Drives request words and register writes into the beep pattern queue player
// and leaves prediction and comparison to the checker. A short directed part
// walks through playback, restarts and removals; random phases then mix
// pattern loads, plays, stops and ticks under several gap and polarity
// settings, with random gaps on the request side and stalls on the result side in all but the first phase.
// ----------------------------------------------------------------------------
module beep_pattern_queue_player_top_tb;
  import bpq_pkg::*;

  localparam int QUEUE_DEPTH  = 8;
  localparam int NUM_PATTERNS = 16;
  localparam int MAX_STEPS    = 16;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_WORDS  = 300;
  localparam int NUM_PHASES   = 4;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_valid   = 1'b0;
  wire                   cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  logic                  in_tvalid   = 1'b0;
  wire                   in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic [IN_USER_W-1:0]  in_tuser    = '0;
  wire                   out_tvalid;
  logic                  out_tready  = 1'b0;
  wire  [OUT_DATA_W-1:0] out_tdata;

  int pending_results;
  int fail_count;
  int results_checked;
  int drops_seen;

  // Stimulus bookkeeping: which store entries of each pattern hold data.
  logic [MAX_STEPS-1:0] loaded_steps [NUM_PATTERNS];
  int                   words_sent    = 0;
  int                   stall_cycles  = 0;
  logic                 quiet_stretch = 1'b0;

  // Register settings of the random phases.
  int   gap_plan    [NUM_PHASES] = '{2, 255, 0, 1};
  logic invert_plan [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0};

  beep_pattern_queue_player_top #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_PATTERNS(NUM_PATTERNS),
    .MAX_STEPS   (MAX_STEPS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  beep_player_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_PATTERNS(NUM_PATTERNS),
    .MAX_STEPS   (MAX_STEPS)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .pending_results(pending_results),
    .fail_count     (fail_count),
    .results_checked(results_checked),
    .drops_seen     (drops_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side stalls on about ten percent of cycles outside the quiet stretch.
  always @(posedge clk) begin
    out_tready <= quiet_stretch || ($urandom_range(99) >= 10);
  end

  // Give up when no channel moves a word for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Write both registers back to back; the player must be idle.
  task automatic write_settings(input logic [7:0] gap, input logic invert);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_PAUSE_TICKS;
    cfg_data  <= gap;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_INVERT_OUTPUT;
    cfg_data  <= {7'd0, invert};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Hold off requests until every status word has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // Send one request word. Loads never advertise a length that reaches an
  // unloaded store entry, and a play of a pattern whose first entry is still
  // empty becomes a load of that entry, so playback only reads loaded data.
  task automatic send_word(input func_t func, input logic [3:0] pat, input logic [3:0] step,
                           input logic [7:0] dur, input logic [4:0] len);
    logic [MAX_STEPS-1:0] mask_next;
    int                   filled;
    int                   want_len;
    if (func == FUNC_PLAY && !loaded_steps[pat][0]) begin
      func = FUNC_LOAD;
      step = '0;
      len  = 5'd1;
    end
    if (func == FUNC_LOAD) begin
      mask_next = loaded_steps[pat] | (MAX_STEPS'(1) << step);
      filled = 0;
      while (filled < MAX_STEPS && mask_next[filled]) filled++;
      want_len = (len > MAX_STEPS) ? MAX_STEPS : int'(len);
      if (want_len > filled) len = filled[4:0];
      loaded_steps[pat] = mask_next;
    end
    if (!quiet_stretch && $urandom_range(99) < 10) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 30);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {3'b000, len, dur, step, pat};
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  function automatic logic [7:0] pick_duration();
    if ($urandom_range(99) < 3) return 8'($urandom_range(255));
    return 8'($urandom_range(4));
  endfunction

  task automatic send_ticks(input int count);
    for (int k = 0; k < count; k++)
      send_word(FUNC_TICK, 4'($urandom_range(15)), 4'($urandom_range(15)),
                8'($urandom_range(255)), 5'($urandom_range(31)));
  endtask

  // Load a whole pattern in step order; a full-length one may carry an
  // oversized length that the player clips.
  task automatic load_pattern(input logic [3:0] pat);
    int steps;
    steps = ($urandom_range(9) == 0) ? MAX_STEPS : $urandom_range(1, 4);
    for (int k = 0; k < steps; k++)
      send_word(FUNC_LOAD, pat, k[3:0], pick_duration(),
                (steps == MAX_STEPS && k == steps - 1) ? 5'($urandom_range(16, 31))
                                                       : 5'(k + 1));
  endtask

  // Mostly well-formed play traffic over loaded patterns, with some noise.
  task automatic random_traffic(input int stop_at);
    int          choice;
    logic [3:0]  pat;
    while (words_sent < stop_at) begin
      choice = $urandom_range(99);
      pat    = 4'($urandom_range(15));
      if (choice < 30) begin
        send_ticks($urandom_range(1, 6));
      end else if (choice < 40) begin
        load_pattern(pat);
      end else if (choice < 75) begin
        for (int k = 0; k < NUM_PATTERNS && !loaded_steps[pat][0]; k++) pat = pat + 4'd1;
        send_word(FUNC_PLAY, pat, 4'($urandom_range(15)), 8'($urandom_range(255)),
                  5'($urandom_range(31)));
      end else if (choice < 85) begin
        send_word(FUNC_STOP, pat, 4'($urandom_range(15)), 8'($urandom_range(255)),
                  5'($urandom_range(31)));
      end else begin
        send_word(FUNC_LOAD, pat, 4'($urandom_range(15)),
                  ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : pick_duration(),
                  5'($urandom_range(31)));
      end
    end
  endtask

  initial begin : stimulus
    for (int p = 0; p < NUM_PATTERNS; p++) loaded_steps[p] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    write_settings(8'd0, 1'b0);

    // Idle tick and stop with an empty queue.
    send_word(FUNC_TICK, 4'hf, 4'hf, 8'hff, 5'h1f);
    send_word(FUNC_STOP, 4'd5, 4'd0, 8'd0, 5'd0);
    // Pattern 0 has no length; pattern 1 has a zero and a nonzero duration.
    send_word(FUNC_LOAD, 4'd0, 4'd0, 8'd1, 5'd0);
    send_word(FUNC_LOAD, 4'd1, 4'd0, 8'd0, 5'd1);
    send_word(FUNC_LOAD, 4'd1, 4'd1, 8'd2, 5'd2);
    send_word(FUNC_LOAD, 4'd15, 4'd15, 8'd255, 5'd0);
    // Replaying the playing head keeps it and appends a second copy.
    send_word(FUNC_PLAY, 4'd1, 4'd0, 8'd0, 5'd0);
    send_word(FUNC_PLAY, 4'd0, 4'd0, 8'd0, 5'd0);
    send_word(FUNC_PLAY, 4'd1, 4'd0, 8'd0, 5'd0);
    send_ticks(4);
    // In the gap the head is no longer protected from a stop.
    send_word(FUNC_STOP, 4'd0, 4'd0, 8'd0, 5'd0);
    send_word(FUNC_PLAY, 4'd0, 4'd0, 8'd0, 5'd0);
    // Restart after the gap, then the empty pattern still plays its first entry.
    send_ticks(6);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain_results();
      write_settings(gap_plan[phase][7:0], invert_plan[phase]);
      quiet_stretch = (phase == 0);
      random_traffic(words_sent + PHASE_WORDS);
    end
    quiet_stretch = 1'b0;

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d request words under %0d register settings, gaps from 0 to 255 ticks.",
             words_sent, NUM_PHASES + 1);
    $display("Compared %0d status words; %0d plays were dropped on a full queue.",
             results_checked, drops_seen);
    if (fail_count == 0 && pending_results == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
src/bpq_pkg.sv
src/bpq_store_ram.sv
src/bpq_queue.sv
src/beep_pattern_queue_player_top.sv
src/bpq_checker.sv
dv/beep_player_checker.sv
dv/beep_pattern_queue_player_top_tb.sv
